### src/pgcb_pkg.sv
// Package for the particle grid cell binner: widths, mode codes, queue item type.
// Used by every module of the block; no dependencies.
package pgcb_pkg;
    localparam int AXIS_BITS  = 4;
    localparam int CELL_BITS  = 12;
    localparam int SLOT_BITS  = 4;
    localparam int CNT_BITS   = 5;
    localparam int ID_W       = 16;
    localparam int NUM_CELLS  = 4096;
    localparam int LIST_CAP   = 16;
    localparam int DIV_STEPS  = 32;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]           mode;
        logic [CELL_BITS-1:0] cell_idx;
        logic [SLOT_BITS-1:0] slot;
        logic [ID_W-1:0]      id;
    } cmd_t;
endpackage

### src/pgcb_front.sv
// Front end: accepts items, computes grid cell of an insert with a bit-serial divider.
// Depends on pgcb_pkg.
module pgcb_front import pgcb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_mode,
    input  logic [31:0] in_px,
    input  logic [31:0] in_py,
    input  logic [31:0] in_pz,
    input  logic [15:0] in_id,
    input  logic [11:0] in_rcell,
    input  logic [3:0]  in_rslot,
    input  logic [30:0] cell_size,
    input  logic [4:0]  cells_x,
    input  logic [4:0]  cells_y,
    input  logic [4:0]  cells_z,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_LIN  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  axis_reg;
    logic [4:0]  step_reg;
    logic [31:0] num_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] py_reg, pz_reg;
    logic [30:0] div_reg;
    logic [4:0]  cx_reg, cy_reg, cz_reg;
    logic [3:0]  ix_reg, iy_reg, iz_reg;
    cmd_t        cmd_reg;
    logic [32:0] trial;
    logic [31:0] rem_sh;
    logic [4:0]  cxl, cyl, czl;
    logic [11:0] lin;

    function automatic logic [4:0] axis_lim(input logic [4:0] n);
        if (n == 5'd0) return 5'd1;
        if (n > 5'd16) return 5'd16;
        return n;
    endfunction

    function automatic logic [3:0] clampq(input logic [31:0] q, input logic b,
                                          input logic [4:0] n);
        logic [31:0] f;
        f = {q[30:0], b};
        if (f > {27'd0, n - 5'd1}) return 4'(n - 5'd1);
        return f[3:0];
    endfunction

    assign cxl = axis_lim(cells_x);
    assign cyl = axis_lim(cells_y);
    assign czl = axis_lim(cells_z);

    // one restoring step per cycle
    assign rem_sh = {rem_reg[30:0], num_reg[31]};
    assign trial  = {1'b0, rem_sh} - {2'b0, div_reg};

    assign lin = 12'({8'd0, iz_reg} * cy_reg * cx_reg) + 12'({8'd0, iy_reg} * cx_reg)
               + {8'd0, ix_reg};

    assign in_ready  = (state_reg == ST_IDLE);
    assign cmd_valid = (state_reg == ST_OUT);
    assign cmd       = cmd_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid)
                state_next = (in_mode == MODE_INSERT) ? ST_DIV : ST_OUT;
            ST_DIV:  if (step_reg == 5'd31 && axis_reg == 2'd2) state_next = ST_LIN;
            ST_LIN:  state_next = ST_OUT;
            ST_OUT:  if (cmd_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_valid) begin
            cmd_reg.mode     <= in_mode;
            cmd_reg.cell_idx <= (in_mode == MODE_READ) ? in_rcell : '0;
            cmd_reg.slot     <= in_rslot;
            cmd_reg.id       <= in_id;
            num_reg  <= in_px[31] ? 32'd0 : in_px;
            py_reg   <= in_py[31] ? 32'd0 : in_py;
            pz_reg   <= in_pz[31] ? 32'd0 : in_pz;
            rem_reg  <= '0;
            quo_reg  <= '0;
            step_reg <= '0;
            axis_reg <= 2'd0;
            div_reg  <= (cell_size == 31'd0) ? 31'd1 : cell_size;
            cx_reg   <= cxl;
            cy_reg   <= cyl;
            cz_reg   <= czl;
        end else if (state_reg == ST_DIV) begin
            if (trial[32]) rem_reg <= rem_sh;
            else rem_reg <= trial[31:0];
            if (step_reg == 5'd31) begin
                // axis finished: store clamped quotient, load next axis
                unique case (axis_reg)
                    2'd0:    ix_reg <= clampq(quo_reg, !trial[32], cx_reg);
                    2'd1:    iy_reg <= clampq(quo_reg, !trial[32], cy_reg);
                    default: iz_reg <= clampq(quo_reg, !trial[32], cz_reg);
                endcase
                num_reg  <= (axis_reg == 2'd0) ? py_reg : pz_reg;
                rem_reg  <= '0;
                quo_reg  <= '0;
                axis_reg <= axis_reg + 2'd1;
            end else begin
                num_reg <= {num_reg[30:0], 1'b0};
                quo_reg <= {quo_reg[30:0], !trial[32]};
            end
            step_reg <= step_reg + 5'd1;
        end else if (state_reg == ST_LIN) begin
            cmd_reg.cell_idx <= lin;
        end
    end
endmodule

### src/pgcb_queue.sv
// Two-entry queue between front end and back end.
// Depends on pgcb_pkg.
module pgcb_queue import pgcb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_data
);
    cmd_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !push) else $error("push to full queue");
endmodule

### src/pgcb_back.sv
// Back end: cell count and list memories, clear sweep, result register.
// Depends on pgcb_pkg.
module pgcb_back import pgcb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] o_cell,
    output logic [3:0]  o_slot,
    output logic        o_stored,
    output logic [4:0]  o_count,
    output logic [15:0] o_id,
    output logic        o_valid
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_CLR  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [CNT_BITS-1:0] count_mem [NUM_CELLS];
    logic [ID_W-1:0]     list_mem  [NUM_CELLS*LIST_CAP];
    logic [1:0]  state_reg, state_next;
    cmd_t        cur_reg;
    logic [CNT_BITS-1:0] cnt_rd_reg;
    logic [ID_W-1:0]     id_rd_reg;
    logic [CELL_BITS:0]  sweep_reg;
    logic        init_reg;
    logic [11:0] r_cell;
    logic [3:0]  r_slot;
    logic        r_stored, r_valid;
    logic [4:0]  r_count;
    logic [15:0] r_id;
    logic        take, full, hit, sweep_end;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign take      = cmd_valid && cmd_ready;
    assign out_valid = (state_reg == ST_OUT);
    assign full      = (cnt_rd_reg >= CNT_BITS'(LIST_CAP));
    assign hit       = ({1'b0, cur_reg.slot} < cnt_rd_reg);
    assign sweep_end = (sweep_reg == 13'(NUM_CELLS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take)
                state_next = (cmd.mode == MODE_CLEAR) ? ST_CLR :
                             (cmd.mode == MODE_INSERT || cmd.mode == MODE_READ) ? ST_RD
                             : ST_OUT;
            ST_RD:   state_next = ST_OUT;
            // the sweep after reset returns no result
            ST_CLR:  if (sweep_end) state_next = init_reg ? ST_IDLE : ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sweep counter and reset clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            sweep_reg <= '0;
            init_reg <= 1'b1;
            cur_reg.mode <= MODE_CLEAR;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLR && sweep_end) init_reg <= 1'b0;
            if (take) begin
                cur_reg <= cmd;
                sweep_reg <= '0;
            end else if (state_reg == ST_CLR) sweep_reg <= sweep_reg + 13'd1;
        end
    end

    // memory ports: one count access, one list access per cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLR) count_mem[sweep_reg[CELL_BITS-1:0]] <= '0;
        else if (state_reg == ST_RD && cur_reg.mode == MODE_INSERT && !full)
            count_mem[cur_reg.cell_idx] <= cnt_rd_reg + 5'd1;
        if (take) cnt_rd_reg <= count_mem[cmd.cell_idx];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD && cur_reg.mode == MODE_INSERT && !full)
            list_mem[{cur_reg.cell_idx, cnt_rd_reg[3:0]}] <= cur_reg.id;
        if (take) id_rd_reg <= list_mem[{cmd.cell_idx, cmd.slot}];
    end

    // result register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD) begin
            r_cell <= cur_reg.cell_idx;
            if (cur_reg.mode == MODE_INSERT) begin
                r_slot <= full ? 4'd0 : cnt_rd_reg[3:0];
                r_stored <= !full;
                r_count <= full ? cnt_rd_reg : cnt_rd_reg + 5'd1;
                r_id <= '0; r_valid <= 1'b0;
            end else begin
                r_slot <= '0; r_stored <= 1'b0;
                r_count <= cnt_rd_reg;
                r_id <= hit ? id_rd_reg : 16'd0;
                r_valid <= hit;
            end
        end else if (take) begin
            r_cell <= '0; r_slot <= '0; r_stored <= 1'b0;
            r_count <= '0; r_id <= '0; r_valid <= 1'b0;
        end
    end

    assign o_cell = r_cell;   assign o_slot = r_slot;   assign o_stored = r_stored;
    assign o_count = r_count; assign o_id = r_id;       assign o_valid = r_valid;

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (o_count <= 5'd16)) else $error("count above capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && o_valid) |-> ({1'b0, o_slot} == 5'd0 && !o_stored))
        else $error("read result carries insert fields");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |=> (state_reg == ST_OUT)) else $error("lookup stalled");
endmodule

### src/particle_grid_cell_binning.sv
// Top level of the particle grid cell binner: config registers, front, queue, back.
// Depends on pgcb_pkg, pgcb_front, pgcb_queue, pgcb_back.
//
//  channel   dir  fields (low bit first)
//  s_axis    in   tdata: mode, pos_x, pos_y, pos_z, particle_id, read_cell, read_slot
//  m_axis    out  tdata: cell_index, slot, stored, entry_count, entry_id, entry_valid
//  cfg       in   cfg_we, cfg_index, cfg_data
//
// An insert goes through the front end's one-bit-a-cycle divider, which
// runs 32 steps on each axis. Read and mode-three items skip the divider.
// A clear sweeps the 4096 cell counts, one a cycle; reset runs the same
// sweep without a result. The queue lets the front end divide while
// the back end waits on a stalled result.
module particle_grid_cell_binning import pgcb_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // mode, pos_x, pos_y, pos_z, particle_id, read_cell, read_slot
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,  // cell_index, slot, stored, entry_count, entry_id, entry_valid
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data
);
    localparam logic [1:0] REG_CELL_SIZE = 2'd0;
    localparam logic [1:0] REG_CELLS_X   = 2'd1;
    localparam logic [1:0] REG_CELLS_Y   = 2'd2;
    localparam logic [1:0] REG_CELLS_Z   = 2'd3;

    logic [30:0] cell_size_reg;
    logic [4:0]  cx_reg, cy_reg, cz_reg;
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    cmd_t fq_cmd, qb_cmd;
    logic [11:0] o_cell; logic [3:0] o_slot; logic o_stored, o_valid;
    logic [4:0] o_count; logic [15:0] o_id;

    // write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_size_reg <= 31'd65536;
            cx_reg <= 5'd16; cy_reg <= 5'd16; cz_reg <= 5'd16;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CELL_SIZE: cell_size_reg <= cfg_data;
                REG_CELLS_X:   cx_reg <= cfg_data[4:0];
                REG_CELLS_Y:   cy_reg <= cfg_data[4:0];
                REG_CELLS_Z:   cz_reg <= cfg_data[4:0];
                default:       cx_reg <= cx_reg;
            endcase
        end
    end

    pgcb_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_mode(s_tdata[1:0]), .in_px(s_tdata[33:2]), .in_py(s_tdata[65:34]),
        .in_pz(s_tdata[97:66]), .in_id(s_tdata[113:98]),
        .in_rcell(s_tdata[125:114]),
        .in_rslot(s_tdata[129:126]),
        .cell_size(cell_size_reg), .cells_x(cx_reg), .cells_y(cy_reg), .cells_z(cz_reg),
        .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
    );

    pgcb_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
    );

    pgcb_back u_back (
        .aclk, .aresetn,
        .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .o_cell, .o_slot, .o_stored, .o_count, .o_id, .o_valid
    );

    assign m_tdata = {1'b0, o_valid, o_id, o_count, o_stored, o_slot, o_cell};
endmodule

### tb/tb_particle_grid_cell_binning.sv
// Testbench for particle_grid_cell_binning: random and directed clear, insert and read
// transactions checked against an in-bench model of the grid. Depends on pgcb_pkg.
module tb_particle_grid_cell_binning;
    import pgcb_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic [1:0] REG_SIZE = 2'd0;
    localparam logic [1:0] REG_CX   = 2'd1;
    localparam logic [1:0] REG_CY   = 2'd2;
    localparam logic [1:0] REG_CZ   = 2'd3;
    localparam int LIMIT_CYCLES = 4000000;

    typedef struct packed {
        logic        entry_valid;
        logic [15:0] entry_id;
        logic [4:0]  entry_count;
        logic        stored;
        logic [3:0]  slot;
        logic [11:0] cell_index;
    } bin_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [135:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [30:0] cfg_data = '0;

    // grid model state
    logic [30:0] grid_size;
    logic [4:0]  grid_cx, grid_cy, grid_cz;
    logic [4:0]  grid_count [NUM_CELLS];
    logic [15:0] grid_ids [NUM_CELLS*LIST_CAP];

    bin_result_t pending_results [$];
    int errors = 0;
    int cycles = 0;
    bit hold_off = 1'b0;

    always #6 aclk = ~aclk;

    particle_grid_cell_binning u_top (.*);

    // limit run length
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [31:0] clamp_axis(logic [4:0] n);
        if (n == 0) return 32'd1;
        if (n > 16) return 32'd16;
        return {27'd0, n};
    endfunction

    function automatic logic [31:0] axis_of(logic [31:0] p, logic [31:0] n);
        logic [31:0] d, q;
        d = (grid_size == 0) ? 32'd1 : {1'b0, grid_size};
        if (p == 0 || p[31]) return 32'd0;
        q = p / d;
        if (q > n - 1) q = n - 1;
        return q;
    endfunction

    // work out the result of one transaction and update the grid
    function automatic bin_result_t bin_predict(logic [1:0] mode, logic [31:0] px,
            logic [31:0] py, logic [31:0] pz, logic [15:0] pid, logic [11:0] rc,
            logic [3:0] rs);
        bin_result_t r;
        logic [31:0] cx, cy, cz, cell_lin;
        logic [4:0] cnt;
        r = '0;
        case (mode)
            MODE_CLEAR: begin
                foreach (grid_count[i]) grid_count[i] = 5'd0;
            end
            MODE_INSERT: begin
                cx = clamp_axis(grid_cx);
                cy = clamp_axis(grid_cy);
                cz = clamp_axis(grid_cz);
                cell_lin = axis_of(px, cx) + axis_of(py, cy) * cx
                         + axis_of(pz, cz) * cx * cy;
                cnt = grid_count[cell_lin];
                r.cell_index = cell_lin[11:0];
                if (cnt < LIST_CAP) begin
                    grid_ids[cell_lin*LIST_CAP + cnt] = pid;
                    r.slot = cnt[3:0];
                    r.stored = 1'b1;
                    cnt++;
                    grid_count[cell_lin] = cnt;
                end
                r.entry_count = cnt;
            end
            MODE_READ: begin
                r.cell_index = rc;
                r.entry_count = grid_count[rc];
                if (rs < grid_count[rc]) begin
                    r.entry_id = grid_ids[rc*LIST_CAP + rs];
                    r.entry_valid = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("error at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        errors++;
    endtask

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        bin_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[38:0];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.cell_index !== want.cell_index)
                    report_mismatch("cell_index", 32'(got.cell_index), 32'(want.cell_index));
                if (got.slot !== want.slot)
                    report_mismatch("slot", 32'(got.slot), 32'(want.slot));
                if (got.stored !== want.stored)
                    report_mismatch("stored", 32'(got.stored), 32'(want.stored));
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(got.entry_count),
                                    32'(want.entry_count));
                if (got.entry_id !== want.entry_id)
                    report_mismatch("entry_id", 32'(got.entry_id), 32'(want.entry_id));
                if (got.entry_valid !== want.entry_valid)
                    report_mismatch("entry_valid", 32'(got.entry_valid),
                                    32'(want.entry_valid));
            end
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else if ($urandom_range(0, 3) == 0) m_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
        else m_tready <= ($urandom_range(0, 4) != 0);
    end

    task automatic hold_receiver(int n);
        hold_off = 1'b1;
        repeat (n) @(posedge aclk);
        hold_off = 1'b0;
    endtask

    // send one transaction and predict its result on acceptance
    task automatic send_item(logic [1:0] mode, logic [31:0] px, logic [31:0] py,
            logic [31:0] pz, logic [15:0] pid, logic [11:0] rc, logic [3:0] rs,
            bit gaps = 1'b1);
        int g;
        g = 1;
        if (gaps && $urandom_range(0, 2) == 0)
            g = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(2, 4);
        repeat (g) @(posedge aclk);
        s_tdata <= {6'd0, rs, rc, pid, pz, py, px, mode};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(bin_predict(mode, px, py, pz, pid, rc, rs));
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_SIZE: grid_size = val;
            REG_CX:   grid_cx = val[4:0];
            REG_CY:   grid_cy = val[4:0];
            REG_CZ:   grid_cz = val[4:0];
            default:  ;
        endcase
    endtask

    task automatic set_grid(logic [30:0] sz, logic [4:0] x, logic [4:0] y, logic [4:0] z);
        wait_drained();
        write_reg(REG_SIZE, sz);
        write_reg(REG_CX, 31'(x));
        write_reg(REG_CY, 31'(y));
        write_reg(REG_CZ, 31'(z));
    endtask

    function automatic logic [31:0] rand_pos(logic [30:0] sz);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return -$urandom_range(0, 1000);
            default: return $urandom_range(0, 20) * sz + $urandom_range(0, 3);
        endcase
    endfunction

    // read a slot that has been written since the last clear, or an empty one
    task automatic send_read();
        logic [11:0] c;
        logic [3:0] s;
        c = 12'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            repeat (20) if (grid_count[c] == 0) c = 12'($urandom_range(0, 63));
        end
        s = 4'($urandom);
        if (grid_count[c] != 0 && $urandom_range(0, 2) != 0)
            s = 4'($urandom_range(0, grid_count[c] - 1));
        send_item(MODE_READ, $urandom, $urandom, $urandom, 16'($urandom), c, s);
    endtask

    task automatic send_insert(logic [30:0] sz);
        send_item(MODE_INSERT, rand_pos(sz), rand_pos(sz), rand_pos(sz), 16'($urandom),
                  12'($urandom), 4'($urandom));
    endtask

    // extremes of position, overflowing a list, every mode
    task automatic test_directed();
        send_item(MODE_INSERT, 32'd0, 32'd0, 32'd0, 16'hffff, 12'hfff, 4'hf);
        send_item(MODE_INSERT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h0000,
                  12'd0, 4'd0);
        send_item(MODE_INSERT, 32'h80000000, 32'h00010000, 32'h0001ffff, 16'h5a5a,
                  12'd0, 4'd0);
        for (int i = 0; i < 17; i++)
            send_item(MODE_INSERT, 32'h00030000, 32'd0, 32'd0, 16'(i), 12'd0, 4'd0);
        send_item(MODE_READ, 32'd0, 32'd0, 32'd0, 16'd0, 12'd3, 4'd15);
        send_item(MODE_READ, 32'd0, 32'd0, 32'd0, 16'd0, 12'hfff, 4'd0);
        send_item(MODE_READ, 32'd0, 32'd0, 32'd0, 16'd0, 12'd0, 4'd0);
        send_item(MODE_NONE, '1, '1, '1, '1, '1, '1);
        send_item(MODE_CLEAR, '1, '1, '1, '1, '1, '1);
        send_item(MODE_READ, 32'd0, 32'd0, 32'd0, 16'd0, 12'd3, 4'd0);
    endtask

    // random traffic under one grid setting
    task automatic test_random(int n, logic [30:0] sz);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 2)
                send_item(MODE_CLEAR, $urandom, $urandom, $urandom, 16'($urandom),
                          12'($urandom), 4'($urandom));
            else if (k < 4)
                send_item(MODE_NONE, $urandom, $urandom, $urandom, 16'($urandom),
                          12'($urandom), 4'($urandom));
            else if (k < 60) send_insert(sz);
            else send_read();
        end
    endtask

    // back-pressure: receiver stops while sender keeps offering
    task automatic test_backpressure();
        fork
            hold_receiver(3000);
            for (int i = 0; i < 30; i++)
                send_item(MODE_READ, 32'd0, 32'd0, 32'd0, 16'd0,
                          12'($urandom_range(0, 15)), 4'd0, 1'b0);
        join
        wait_drained();
    endtask

    initial begin
        grid_size = 31'd65536;
        grid_cx = 5'd16;
        grid_cy = 5'd16;
        grid_cz = 5'd16;
        foreach (grid_count[i]) grid_count[i] = 5'd0;
        foreach (grid_ids[i]) grid_ids[i] = 16'd0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(200, 31'd65536);
        set_grid(31'd1, 5'd1, 5'd1, 5'd1);
        test_random(80, 31'd1);
        set_grid(31'd0, 5'd0, 5'd31, 5'd17);
        test_random(120, 31'd1);
        set_grid(31'h7fffffff, 5'd16, 5'd16, 5'd16);
        test_random(80, 31'h7fffffff);
        test_backpressure();
        set_grid(31'd300000, 5'd3, 5'd2, 5'd2);
        test_random(250, 31'd300000);
        set_grid(31'd65536, 5'd7, 5'd16, 5'd5);
        test_random(300, 31'd65536);
        wait_drained();
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### filelist.f
src/pgcb_pkg.sv
src/pgcb_front.sv
src/pgcb_queue.sv
src/pgcb_back.sv
src/particle_grid_cell_binning.sv
tb/tb_particle_grid_cell_binning.sv
